// ----- rtl/gpio_register_block_macros.svh -----
`ifndef GPIO_REGISTER_BLOCK_MACROS_SVH
`define GPIO_REGISTER_BLOCK_MACROS_SVH

// same-cycle implication
`define GPIO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GPIO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gpio_pkg.sv -----
`default_nettype none

package gpio_pkg;

    localparam int OUT_W  = 54;
    localparam int WORD_W = 6;
    localparam int DATA_W = 32;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [WORD_W-1:0] W_FSEL0   = 6'd0;
    localparam logic [WORD_W-1:0] W_FSEL5   = 6'd5;
    localparam logic [WORD_W-1:0] W_SET0    = 6'd7;
    localparam logic [WORD_W-1:0] W_SET1    = 6'd8;
    localparam logic [WORD_W-1:0] W_CLR0    = 6'd10;
    localparam logic [WORD_W-1:0] W_CLR1    = 6'd11;
    localparam logic [WORD_W-1:0] W_LEV0    = 6'd13;
    localparam logic [WORD_W-1:0] W_LEV1    = 6'd14;
    localparam logic [WORD_W-1:0] W_PUD     = 6'd37;
    localparam logic [WORD_W-1:0] W_PUDCLK0 = 6'd38;
    localparam logic [WORD_W-1:0] W_PUDCLK1 = 6'd39;

    localparam logic [2:0] FSEL_OUTPUT = 3'd1;

    localparam logic [1:0] PULL_DOWN = 2'd1;
    localparam logic [1:0] PULL_UP   = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] word_index;
        logic [DATA_W-1:0] write_data;
        logic [OUT_W-1:0]  pin_levels;
    } t_access;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [OUT_W-1:0]  drive_values;
        logic [OUT_W-1:0]  drive_enables;
        logic [OUT_W-1:0]  pull_up_mask;
        logic [OUT_W-1:0]  pull_down_mask;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/gpio_register_block.sv -----
// an accepted transaction waits in the input register; its result is registered in the output register
// throughput: one transaction per cycle while the output is not stalled, set by the single register update step
// a stalled result blocks the output register; the input register can still hold one new transaction
// reset: synchronous active low, clears function codes, output latch, pull
// control, pull clocks and pull states, and empties both pipeline stages
`default_nettype none
`include "gpio_register_block_macros.svh"

module gpio_register_block #(
    parameter int PIN_COUNT = 54
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_cmd,
    input  wire logic [5:0]  i_word_index,
    input  wire logic [31:0] i_write_data,
    input  wire logic [53:0] i_pin_levels,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_read_data,
    output logic [53:0]      o_drive_values,
    output logic [53:0]      o_drive_enables,
    output logic [53:0]      o_pull_up_mask,
    output logic [53:0]      o_pull_down_mask
);
    import gpio_pkg::*;

    t_access in_access;
    t_access acc_q;
    t_result res_d;
    t_result res_q;
    logic    acc_valid;
    logic    out_ready;
    logic    fire;

    assign in_access.cmd        = i_cmd;
    assign in_access.word_index = i_word_index;
    assign in_access.write_data = i_write_data;
    assign in_access.pin_levels = i_pin_levels;

    assign fire = acc_valid && out_ready;

    gpio_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_access (in_access),
        .i_fire   (fire),
        .o_valid  (acc_valid),
        .o_access (acc_q)
    );

    gpio_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_access (acc_q),
        .o_result (res_d)
    );

    gpio_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_result (res_d),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (res_q)
    );

    assign o_read_data      = res_q.read_data;
    assign o_drive_values   = res_q.drive_values;
    assign o_drive_enables  = res_q.drive_enables;
    assign o_pull_up_mask   = res_q.pull_up_mask;
    assign o_pull_down_mask = res_q.pull_down_mask;

    `GPIO_ASSERT_NEXT(a_write_reads_zero, i_clk, i_rst_n, fire && acc_q.cmd == CMD_WRITE, o_read_data == 32'd0, "write transaction returned nonzero read data")
    `GPIO_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, fire, o_out_valid, "processed transaction produced no result")
    `GPIO_ASSERT_NEXT(a_held_access_kept, i_clk, i_rst_n, acc_valid && !fire, acc_valid, "pending transaction dropped from input register")
    `GPIO_ASSERT_NEXT(a_set_pin0, i_clk, i_rst_n, fire && acc_q.cmd == CMD_WRITE && acc_q.word_index == W_SET0 && acc_q.write_data[0], o_drive_values[0], "set word did not raise pin 0 latch")
    `GPIO_ASSERT_NOW(a_in_stall_only_when_full, i_clk, i_rst_n, o_in_stall, acc_valid, "input stalled with empty input register")

endmodule

`default_nettype wire

// ----- rtl/gpio_in_stage.sv -----
`default_nettype none

module gpio_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire gpio_pkg::t_access i_access,
    input  wire logic              i_fire,
    output logic                   o_valid,
    output gpio_pkg::t_access      o_access
);
    import gpio_pkg::*;

    logic    r_valid;
    t_access r_access;
    logic    accept;

    assign o_stall = r_valid && !i_fire;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_access <= i_access;
        end
    end

    assign o_valid  = r_valid;
    assign o_access = r_access;

endmodule

`default_nettype wire

// ----- rtl/gpio_regs.sv -----
`default_nettype none

module gpio_regs #(
    parameter int PIN_COUNT = 54
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire gpio_pkg::t_access i_access,
    output gpio_pkg::t_result      o_result
);
    import gpio_pkg::*;

    localparam logic [63:0] PIN_MASK =
        (PIN_COUNT >= 64) ? {64{1'b1}} : ((64'd1 << PIN_COUNT) - 64'd1);

    logic [2:0]           r_fsel [PIN_COUNT];
    logic [2:0]           n_fsel [PIN_COUNT];
    logic [1:0]           r_pull [PIN_COUNT];
    logic [1:0]           n_pull [PIN_COUNT];
    logic [PIN_COUNT-1:0] r_latch;
    logic [PIN_COUNT-1:0] n_latch;
    logic [1:0]           r_pud;
    logic [1:0]           n_pud;
    logic [31:0]          r_clk_lo;
    logic [31:0]          n_clk_lo;
    logic [21:0]          r_clk_hi;
    logic [21:0]          n_clk_hi;

    always_comb begin
        logic        wr;
        logic [31:0] rd;
        logic [63:0] lev64;
        logic [63:0] data_lo;
        logic [63:0] data_hi;
        logic [63:0] set_m;
        logic [63:0] clr_m;
        logic [63:0] clk_sel;
        logic [63:0] latch64;
        logic [63:0] en64;
        logic [63:0] up64;
        logic [63:0] dn64;

        n_fsel   = r_fsel;
        n_pull   = r_pull;
        n_pud    = r_pud;
        n_clk_lo = r_clk_lo;
        n_clk_hi = r_clk_hi;
        wr       = (i_access.cmd == CMD_WRITE);
        rd       = '0;
        set_m    = '0;
        clr_m    = '0;
        clk_sel  = '0;
        en64     = '0;
        up64     = '0;
        dn64     = '0;
        lev64    = 64'(i_access.pin_levels) & PIN_MASK;
        data_lo  = 64'(i_access.write_data) & PIN_MASK;
        data_hi  = {i_access.write_data, 32'h0} & PIN_MASK;

        unique case (i_access.word_index) inside
            [W_FSEL0:W_FSEL5]: begin
                for (int p = 0; p < PIN_COUNT; p++) begin
                    if ((p / 10) <= 5 && i_access.word_index == WORD_W'(p / 10)) begin
                        if (wr) begin
                            n_fsel[p] = i_access.write_data[3*(p%10) +: 3];
                        end else begin
                            rd[3*(p%10) +: 3] = r_fsel[p];
                        end
                    end
                end
            end
            W_SET0: begin
                if (wr) set_m = data_lo;
            end
            W_SET1: begin
                if (wr) set_m = data_hi;
            end
            W_CLR0: begin
                if (wr) clr_m = data_lo;
            end
            W_CLR1: begin
                if (wr) clr_m = data_hi;
            end
            W_LEV0: begin
                if (!wr) rd = lev64[31:0];
            end
            W_LEV1: begin
                if (!wr) rd = lev64[63:32];
            end
            W_PUD: begin
                if (wr) begin
                    n_pud = i_access.write_data[1:0];
                end else begin
                    rd = 32'(r_pud);
                end
            end
            W_PUDCLK0: begin
                if (wr) begin
                    n_clk_lo = data_lo[31:0];
                    clk_sel  = data_lo;
                end else begin
                    rd = r_clk_lo;
                end
            end
            W_PUDCLK1: begin
                if (wr) begin
                    n_clk_hi = data_hi[53:32];
                    clk_sel  = data_hi;
                end else begin
                    rd = 32'(r_clk_hi);
                end
            end
            default: begin
            end
        endcase

        n_latch = (r_latch | set_m[PIN_COUNT-1:0]) & ~clr_m[PIN_COUNT-1:0];

        for (int i = 0; i < PIN_COUNT; i++) begin
            if (clk_sel[i]) n_pull[i] = r_pud;
        end

        for (int i = 0; i < PIN_COUNT; i++) begin
            en64[i] = (n_fsel[i] == FSEL_OUTPUT);
            up64[i] = (n_pull[i] == PULL_UP);
            dn64[i] = (n_pull[i] == PULL_DOWN);
        end

        latch64                 = 64'(n_latch);
        o_result.read_data      = rd;
        o_result.drive_values   = latch64[OUT_W-1:0];
        o_result.drive_enables  = en64[OUT_W-1:0];
        o_result.pull_up_mask   = up64[OUT_W-1:0];
        o_result.pull_down_mask = dn64[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_fsel[i] <= '0;
                r_pull[i] <= '0;
            end
            r_latch  <= '0;
            r_pud    <= '0;
            r_clk_lo <= '0;
            r_clk_hi <= '0;
        end else if (i_fire) begin
            r_fsel   <= n_fsel;
            r_pull   <= n_pull;
            r_latch  <= n_latch;
            r_pud    <= n_pud;
            r_clk_lo <= n_clk_lo;
            r_clk_hi <= n_clk_hi;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gpio_out_stage.sv -----
`default_nettype none

module gpio_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire gpio_pkg::t_result i_result,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output gpio_pkg::t_result      o_result
);
    import gpio_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
